>>> rtl/multi_alarm_countdown_timer_unit_assert.svh
// assertion macros for the countdown timer unit
// expects clk and rst_n in the scope of each use
`ifndef MULTI_ALARM_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define MULTI_ALARM_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

// property that holds at every edge outside reset
`define MACD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define MACD_ASSERT_NEXT(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> rtl/macd_pkg.sv
// types and codes shared by the countdown timer unit
// no dependencies
`timescale 1ns / 1ps

package macd_pkg;

    localparam logic [1:0] REQ_SECOND = 2'd0;
    localparam logic [1:0] REQ_FAST   = 2'd1;
    localparam logic [1:0] REQ_SET    = 2'd2;
    localparam logic [1:0] REQ_CANCEL = 2'd3;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_DUP     = 3'd2;
    localparam logic [2:0] STAT_NO_SLOT = 3'd3;
    localparam logic [2:0] STAT_ZERO    = 3'd4;

    localparam logic [1:0] REG_SECS_PER_MIN = 2'd0;
    localparam logic [1:0] REG_BUZZER_DELAY = 2'd1;
    localparam logic [1:0] REG_LIGHT_HOLD   = 2'd2;
    localparam logic [1:0] REG_BLINK_PERIOD = 2'd3;

    localparam logic [5:0] SECS_PER_MIN_RST = 6'd60;
    localparam logic [6:0] BUZZER_DELAY_RST = 7'd10;
    localparam logic [3:0] LIGHT_HOLD_RST   = 4'd3;
    localparam logic [5:0] BLINK_PERIOD_RST = 6'd32;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] alarm_minutes;
        logic [1:0]  cancel_slot;
        logic        light_detected;
    } req_t;

    typedef struct packed {
        logic        buzzer_drive;
        logic        leds_on;
        logic [1:0]  alarms_active;
        logic [15:0] nearest_minutes;
        logic        nearest_valid;
        logic [2:0]  cmd_status;
        logic        fired;
    } rsp_t;

    typedef struct packed {
        logic [5:0] secs_per_min;
        logic [6:0] buzzer_delay;
        logic [3:0] light_hold;
        logic [5:0] blink_period;
    } cfg_t;

    typedef struct packed {
        logic       fired;
        logic [2:0] status;
    } tbl_stat_t;

    typedef struct packed {
        logic buzzer_drive;
        logic leds_on;
    } alm_stat_t;

endpackage

>>> rtl/multi_alarm_countdown_timer_unit.sv
// top level: config registers, input register, result register
// depends on macd_pkg, macd_table, macd_alarm and the assertion header
//
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  macd_pkg::req_t
// rsp       out        rsp_valid/rsp_ready  macd_pkg::rsp_t
// cfg       in         psel/penable/pready  paddr, pwdata, prdata
//
// one item per cycle sustained while rsp_ready stays high, set by the single update pass on the table
// an accepted item waits in the input register, then moves to the result register once that is empty or being taken
// reset loads default config and clears counts and flags; table entries are not reset
// a held result stalls the input register, and req_ready drops once both are full
`timescale 1ns / 1ps
`include "multi_alarm_countdown_timer_unit_assert.svh"

module multi_alarm_countdown_timer_unit #(
    parameter int SLOTS       = 3,
    parameter int MINUTE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  macd_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output macd_pkg::rsp_t rsp_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    macd_pkg::cfg_t      cfg_reg;
    macd_pkg::cfg_t      cfg_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    macd_pkg::req_t      s1_data_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    macd_pkg::rsp_t      rsp_data_reg;
    macd_pkg::rsp_t      rsp_data_next;

    logic                advance;
    logic                out_blocked;
    logic                minute;
    logic [1:0]          reg_idx;
    macd_pkg::tbl_stat_t tstat;
    macd_pkg::alm_stat_t astat;
    logic [1:0]          alarms_active;
    logic [15:0]         nearest_minutes;
    logic                nearest_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                macd_pkg::REG_SECS_PER_MIN: cfg_next.secs_per_min = pwdata[5:0];
                macd_pkg::REG_BUZZER_DELAY: cfg_next.buzzer_delay = pwdata[6:0];
                macd_pkg::REG_LIGHT_HOLD:   cfg_next.light_hold   = pwdata[3:0];
                macd_pkg::REG_BLINK_PERIOD: cfg_next.blink_period = pwdata[5:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            macd_pkg::REG_SECS_PER_MIN: prdata = 32'(cfg_reg.secs_per_min);
            macd_pkg::REG_BUZZER_DELAY: prdata = 32'(cfg_reg.buzzer_delay);
            macd_pkg::REG_LIGHT_HOLD:   prdata = 32'(cfg_reg.light_hold);
            macd_pkg::REG_BLINK_PERIOD: prdata = 32'(cfg_reg.blink_period);
            default:                    prdata = 32'd0;
        endcase
    end

    assign advance        = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign out_blocked    = s1_valid_reg && rsp_valid_reg && !rsp_ready;
    assign req_ready      = !s1_valid_reg || advance;
    assign s1_valid_next  = (req_valid && req_ready) || (s1_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp_ready);

    macd_table #(
        .SLOTS       (SLOTS),
        .MINUTE_BITS (MINUTE_BITS)
    ) u_table (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (advance),
        .req             (s1_data_reg),
        .minute          (minute),
        .stat            (tstat),
        .alarms_active   (alarms_active),
        .nearest_minutes (nearest_minutes),
        .nearest_valid   (nearest_valid)
    );

    macd_alarm u_alarm (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .req    (s1_data_reg),
        .cfg    (cfg_reg),
        .tstat  (tstat),
        .minute (minute),
        .astat  (astat)
    );

    always_comb
    begin
        rsp_data_next                 = rsp_data_reg;
        if (advance)
        begin
            rsp_data_next.buzzer_drive    = astat.buzzer_drive;
            rsp_data_next.leds_on         = astat.leds_on;
            rsp_data_next.alarms_active   = alarms_active;
            rsp_data_next.nearest_minutes = nearest_minutes;
            rsp_data_next.nearest_valid   = nearest_valid;
            rsp_data_next.cmd_status      = tstat.status;
            rsp_data_next.fired           = tstat.fired;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.secs_per_min <= macd_pkg::SECS_PER_MIN_RST;
            cfg_reg.buzzer_delay <= macd_pkg::BUZZER_DELAY_RST;
            cfg_reg.light_hold   <= macd_pkg::LIGHT_HOLD_RST;
            cfg_reg.blink_period <= macd_pkg::BLINK_PERIOD_RST;
            s1_valid_reg         <= 1'b0;
            rsp_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_data_reg <= req_data;
        end
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    `MACD_ASSERT(a_ready_only_when_full, !req_ready |-> out_blocked, "input stalled with room downstream")
    `MACD_ASSERT_NEXT(a_result_follows, advance, rsp_valid_reg, "processed item produced no result")

endmodule

>>> rtl/macd_table.sv
// compacted countdown table: set, cancel, minute decrement and nearest entry
// depends on macd_pkg and the assertion header
`timescale 1ns / 1ps
`include "multi_alarm_countdown_timer_unit_assert.svh"

module macd_table #(
    parameter int SLOTS       = 3,
    parameter int MINUTE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  macd_pkg::req_t      req,
    input  logic                minute,
    output macd_pkg::tbl_stat_t stat,
    output logic [1:0]          alarms_active,
    output logic [15:0]         nearest_minutes,
    output logic                nearest_valid
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int LEAVES = 1 << $clog2(SLOTS);
    localparam int WW = (MINUTE_BITS > 16) ? MINUTE_BITS : 16;

    logic [MINUTE_BITS-1:0] table_reg  [SLOTS];
    logic [MINUTE_BITS-1:0] table_next [SLOTS];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic [MINUTE_BITS-1:0] mins;
    logic [MINUTE_BITS-1:0] dec        [SLOTS];
    logic [SLOTS-1:0]       live;
    logic [SLOTS-1:0]       keep;
    logic [CNT_W-1:0]       pos        [SLOTS];
    logic [MINUTE_BITS-1:0] node       [2*LEAVES-1];
    logic [WW-1:0]          near_wide;

    always_comb
    begin
        mins = MINUTE_BITS'(req.alarm_minutes);
        for (int i = 0; i < SLOTS; i++)
        begin
            dec[i]  = table_reg[i] - MINUTE_BITS'(1);
            live[i] = CNT_W'(i) < count_reg;
            keep[i] = live[i] && (dec[i] != '0);
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            pos[i] = CNT_W'($countones(keep & ((SLOTS'(1) << i) - SLOTS'(1))));
        end
    end

    always_comb
    begin
        table_next  = table_reg;
        count_next  = count_reg;
        stat.fired  = 1'b0;
        stat.status = macd_pkg::STAT_OK;
        if (en)
        begin
            unique case (req.req_type)
                macd_pkg::REQ_SECOND:
                begin
                    if (minute)
                    begin
                        stat.fired = |(live & ~keep);
                        count_next = CNT_W'($countones(keep));
                        for (int j = 0; j < SLOTS; j++)
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (keep[i] && pos[i] == CNT_W'(j))
                                begin
                                    table_next[j] = dec[i];
                                end
                            end
                        end
                    end
                end
                macd_pkg::REQ_FAST:
                begin
                end
                macd_pkg::REQ_SET:
                begin
                    if (32'(count_reg) >= SLOTS)
                    begin
                        stat.status = macd_pkg::STAT_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (live[i] && table_reg[i] == mins)
                            begin
                                stat.status = macd_pkg::STAT_DUP;
                            end
                        end
                        if (stat.status == macd_pkg::STAT_OK && mins == '0)
                        begin
                            stat.status = macd_pkg::STAT_ZERO;
                        end
                        if (stat.status == macd_pkg::STAT_OK)
                        begin
                            for (int j = 0; j < SLOTS; j++)
                            begin
                                if (CNT_W'(j) == count_reg)
                                begin
                                    table_next[j] = mins;
                                end
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                macd_pkg::REQ_CANCEL:
                begin
                    if (32'(req.cancel_slot) >= 32'(count_reg))
                    begin
                        stat.status = macd_pkg::STAT_NO_SLOT;
                    end
                    else
                    begin
                        for (int j = 0; j < SLOTS - 1; j++)
                        begin
                            if (32'(j) >= 32'(req.cancel_slot))
                            begin
                                table_next[j] = table_reg[j+1];
                            end
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // min tree over the updated table, empty leaves read as all ones
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            node[LEAVES-1+i] = '1;
            if (i < SLOTS)
            begin
                if (CNT_W'(i) < count_next)
                begin
                    node[LEAVES-1+i] = table_next[i];
                end
            end
        end
        for (int n = LEAVES - 2; n >= 0; n--)
        begin
            node[n] = (node[2*n+2] < node[2*n+1]) ? node[2*n+2] : node[2*n+1];
        end
        near_wide     = WW'(node[0]);
        nearest_valid = count_next != '0;
        if (!nearest_valid)
        begin
            nearest_minutes = 16'd0;
        end
        else if (near_wide > WW'(16'hFFFF))
        begin
            nearest_minutes = 16'hFFFF;
        end
        else
        begin
            nearest_minutes = near_wide[15:0];
        end
        alarms_active = (32'(count_next) > 32'd3) ? 2'd3 : 2'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        table_reg <= table_next;
    end

    `MACD_ASSERT(a_count_bound, 32'(count_reg) <= SLOTS, "pending count beyond table size")
    `MACD_ASSERT(a_status_on_cmd, (stat.status != macd_pkg::STAT_OK) |-> (en && (req.req_type == macd_pkg::REQ_SET || req.req_type == macd_pkg::REQ_CANCEL)), "status raised without a command")

endmodule

>>> rtl/macd_alarm.sv
// prescaler, arming, buzzer delay, light dismissal and led blinking
// depends on macd_pkg and the assertion header
`timescale 1ns / 1ps
`include "multi_alarm_countdown_timer_unit_assert.svh"

module macd_alarm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  macd_pkg::req_t      req,
    input  macd_pkg::cfg_t      cfg,
    input  macd_pkg::tbl_stat_t tstat,
    output logic                minute,
    output macd_pkg::alm_stat_t astat
);

    logic [5:0]        prescale_reg;
    logic [5:0]        prescale_next;
    logic              armed_reg;
    logic              armed_next;
    logic signed [7:0] wait_reg;
    logic signed [7:0] wait_next;
    logic [3:0]        run_reg;
    logic [3:0]        run_next;
    logic              blink_reg;
    logic              blink_next;
    logic [5:0]        ticks_reg;
    logic [5:0]        ticks_next;
    logic              leds_reg;
    logic              leds_next;

    logic [5:0]        presc_inc;
    logic [5:0]        ticks_inc;

    assign presc_inc = prescale_reg + 6'd1;
    assign ticks_inc = ticks_reg + 6'd1;
    assign minute    = en && (req.req_type == macd_pkg::REQ_SECOND)
                       && (presc_inc >= cfg.secs_per_min);

    always_comb
    begin
        prescale_next = prescale_reg;
        armed_next    = armed_reg;
        wait_next     = wait_reg;
        run_next      = run_reg;
        blink_next    = blink_reg;
        ticks_next    = ticks_reg;
        leds_next     = leds_reg;
        if (en)
        begin
            unique case (req.req_type)
                macd_pkg::REQ_SECOND:
                begin
                    prescale_next = minute ? 6'd0 : presc_inc;
                    if (tstat.fired)
                    begin
                        if (!armed_reg)
                        begin
                            wait_next = 8'(cfg.buzzer_delay);
                        end
                        armed_next = 1'b1;
                        blink_next = 1'b1;
                    end
                    if (armed_next && wait_next > -8'sd1)
                    begin
                        wait_next = wait_next - 8'sd1;
                    end
                    if (req.light_detected)
                    begin
                        run_next = (run_reg != 4'hF) ? run_reg + 4'd1 : run_reg;
                    end
                    else
                    begin
                        run_next = 4'd0;
                    end
                    // dismiss
                    if (run_next >= cfg.light_hold)
                    begin
                        armed_next = 1'b0;
                        wait_next  = 8'(cfg.buzzer_delay);
                        run_next   = 4'd0;
                        blink_next = 1'b0;
                        leds_next  = 1'b0;
                    end
                end
                macd_pkg::REQ_FAST:
                begin
                    if (blink_reg)
                    begin
                        if (ticks_inc >= cfg.blink_period)
                        begin
                            ticks_next = 6'd0;
                            leds_next  = !leds_reg;
                        end
                        else
                        begin
                            ticks_next = ticks_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign astat.buzzer_drive = armed_next && wait_next[7];
    assign astat.leds_on      = leds_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 6'd0;
            armed_reg    <= 1'b0;
            wait_reg     <= 8'(macd_pkg::BUZZER_DELAY_RST);
            run_reg      <= 4'd0;
            blink_reg    <= 1'b0;
            ticks_reg    <= 6'd0;
            leds_reg     <= 1'b0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            armed_reg    <= armed_next;
            wait_reg     <= wait_next;
            run_reg      <= run_next;
            blink_reg    <= blink_next;
            ticks_reg    <= ticks_next;
            leds_reg     <= leds_next;
        end
    end

    `MACD_ASSERT(a_wait_floor, wait_reg >= -8'sd1, "buzzer wait below minus one")
    `MACD_ASSERT(a_leds_need_blink, leds_reg |-> blink_reg, "leds lit while blinking stopped")

endmodule
